### design/rfd_pkg.sv
package rfd_pkg;

	// Frame phases of the deframer.
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LCS  = 3'd1,
		PH_TFI  = 3'd2,
		PH_CODE = 3'd3,
		PH_DATA = 3'd4,
		PH_DCS  = 3'd5,
		PH_POST = 3'd6
	} phase_t;

	// Frame outcome codes carried in a status beat.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LEN_CSUM = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_BAD_ID   = 3'd3,
		ST_BAD_CODE = 3'd4,
		ST_DAT_CSUM = 3'd5
	} status_t;

	// Register indexes on the configuration port (byte address is 4 times this).
	localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
	localparam logic [1:0] REG_EXP_CMD    = 2'd1;
	localparam logic [1:0] REG_HOST_FID   = 2'd2;

	// Register reset values.
	localparam logic [7:0] MAX_LENGTH_RST = 8'hFF;
	localparam logic [7:0] EXP_CMD_RST    = 8'h00;
	localparam logic [7:0] HOST_FID_RST   = 8'hD5;

	// Configuration seen by the frame checker.
	typedef struct packed {
		logic [7:0] max_length;
		logic [7:0] expected_command;
		logic [7:0] host_frame_id;
	} cfg_t;

	// Result produced by one byte.
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       is_status;
		status_t    status;
	} res_t;

endpackage

### design/response_frame_deframer.sv
// Response frame deframer: takes the received bytes of a controller response
// frame, starting at the length byte (marked by s_tuser), checks the length and
// its checksum, the frame identifier, the response code and the data checksum,
// and passes on the payload bytes followed by one status beat with tlast set.
// It takes one byte per clock cycle while the output side does not stall; each
// byte goes through an input register, one pass of the frame checker and a
// result register, so its result is presented from the result register. The
// result register is the only buffer on the output side: while it holds a beat
// that is not taken in the current cycle, the byte in the input register waits
// and no new byte is taken. The user must write configuration over the APB
// port only while no frame is in flight; the block does not enforce this.
module response_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// Input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] frame_start
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_byte
	output logic [3:0]  m_tuser,   // [0] is_status, [3:1] status
	output logic        m_tlast,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rfd_pkg::cfg_t   cfg_q;
	rfd_pkg::res_t   res;
	rfd_pkg::phase_t phase;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       out_free;
	logic       step;

	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_is_status_q;
	logic [2:0] m_status_q;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length       <= rfd_pkg::MAX_LENGTH_RST;
			cfg_q.expected_command <= rfd_pkg::EXP_CMD_RST;
			cfg_q.host_frame_id    <= rfd_pkg::HOST_FID_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				rfd_pkg::REG_MAX_LENGTH: cfg_q.max_length       <= pwdata[7:0];
				rfd_pkg::REG_EXP_CMD:    cfg_q.expected_command <= pwdata[7:0];
				rfd_pkg::REG_HOST_FID:   cfg_q.host_frame_id    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			rfd_pkg::REG_MAX_LENGTH: prdata = {24'd0, cfg_q.max_length};
			rfd_pkg::REG_EXP_CMD:    prdata = {24'd0, cfg_q.expected_command};
			rfd_pkg::REG_HOST_FID:   prdata = {24'd0, cfg_q.host_frame_id};
			default:                 prdata = '0;
		endcase
	end

	// The byte in the input register is processed when the result register can
	// take whatever it produces.
	assign out_free = !m_valid_q || m_tready;
	assign step     = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	// Frame checker.
	rfd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.cfg         (cfg_q),
		.res         (res),
		.phase       (phase)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			m_data_q      <= res.data_byte;
			m_is_status_q <= res.is_status;
			m_status_q    <= res.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = {m_status_q, m_is_status_q};
	assign m_tlast  = m_is_status_q;

	// A length byte never produces a beat.
	a_start_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(step && start_s1) |=> !m_tvalid)
		else $error("length byte produced a result beat");

	// After a status beat is produced the checker has left the frame.
	a_status_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.is_status) |=>
		(phase == rfd_pkg::PH_IDLE || phase == rfd_pkg::PH_POST))
		else $error("checker still inside a frame after a status beat");

	// Payload beats carry no status code.
	a_data_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tuser[3:1] == rfd_pkg::ST_OK))
		else $error("payload beat carries a status code");

endmodule

### design/rfd_core.sv
module rfd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	input  rfd_pkg::cfg_t      cfg,
	output rfd_pkg::res_t      res,
	output rfd_pkg::phase_t    phase
);

	rfd_pkg::phase_t phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] idx_q, idx_d;
	logic [7:0] sum_q, sum_d;
	logic       id_ok_q, id_ok_d;
	logic       code_ok_q, code_ok_d;

	logic [7:0] sum_add;
	logic [7:0] idx_inc;
	logic [8:0] code_want;

	assign sum_add   = sum_q + rx_byte;
	assign idx_inc   = idx_q + 8'd1;
	assign code_want = {1'b0, cfg.expected_command} + 9'd1;
	assign phase     = phase_q;

	// State registers; they move only when a byte is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rfd_pkg::PH_IDLE;
			len_q     <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			id_ok_q   <= 1'b0;
			code_ok_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			len_q     <= len_d;
			idx_q     <= idx_d;
			sum_q     <= sum_d;
			id_ok_q   <= id_ok_d;
			code_ok_q <= code_ok_d;
		end
	end

	// Next state and result for the byte at the input.
	always_comb begin
		phase_d       = phase_q;
		len_d         = len_q;
		idx_d         = idx_q;
		sum_d         = sum_q;
		id_ok_d       = id_ok_q;
		code_ok_d     = code_ok_q;
		res.valid     = 1'b0;
		res.data_byte = '0;
		res.is_status = 1'b0;
		res.status    = rfd_pkg::ST_OK;
		if (frame_start) begin
			// A length byte restarts framing from any phase.
			len_d     = rx_byte;
			idx_d     = '0;
			sum_d     = '0;
			id_ok_d   = 1'b0;
			code_ok_d = 1'b0;
			phase_d   = rfd_pkg::PH_LCS;
		end else begin
			unique case (phase_q)
				rfd_pkg::PH_LCS: begin
					if ((len_q + rx_byte) != 8'd0) begin
						phase_d       = rfd_pkg::PH_IDLE;
						res.valid     = 1'b1;
						res.is_status = 1'b1;
						res.status    = rfd_pkg::ST_LEN_CSUM;
					end else if (len_q > cfg.max_length) begin
						phase_d       = rfd_pkg::PH_IDLE;
						res.valid     = 1'b1;
						res.is_status = 1'b1;
						res.status    = rfd_pkg::ST_TOO_LONG;
					end else begin
						sum_d   = '0;
						idx_d   = '0;
						phase_d = (len_q == 8'd0) ? rfd_pkg::PH_DCS : rfd_pkg::PH_TFI;
					end
				end
				rfd_pkg::PH_TFI: begin
					sum_d   = sum_add;
					id_ok_d = (rx_byte == cfg.host_frame_id) && (len_q >= 8'd2);
					idx_d   = 8'd1;
					phase_d = (len_q <= 8'd1) ? rfd_pkg::PH_DCS : rfd_pkg::PH_CODE;
				end
				rfd_pkg::PH_CODE: begin
					sum_d     = sum_add;
					code_ok_d = ({1'b0, rx_byte} == code_want);
					idx_d     = 8'd2;
					phase_d   = (len_q <= 8'd2) ? rfd_pkg::PH_DCS : rfd_pkg::PH_DATA;
				end
				rfd_pkg::PH_DATA: begin
					sum_d         = sum_add;
					idx_d         = idx_inc;
					if (idx_inc >= len_q) begin
						phase_d = rfd_pkg::PH_DCS;
					end
					res.valid     = 1'b1;
					res.data_byte = rx_byte;
				end
				rfd_pkg::PH_DCS: begin
					// Late errors in priority order: checksum, identifier, code.
					phase_d       = rfd_pkg::PH_POST;
					res.valid     = 1'b1;
					res.is_status = 1'b1;
					if (sum_add != 8'd0) begin
						res.status = rfd_pkg::ST_DAT_CSUM;
					end else if (!id_ok_q) begin
						res.status = rfd_pkg::ST_BAD_ID;
					end else if (!code_ok_q) begin
						res.status = rfd_pkg::ST_BAD_CODE;
					end else begin
						res.status = rfd_pkg::ST_OK;
					end
				end
				rfd_pkg::PH_POST: begin
					phase_d = rfd_pkg::PH_IDLE;
				end
				default: begin
					// Idle: stray bytes are dropped.
					phase_d = rfd_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule
